[rtl/mgtt_pkg.sv]
// ----------------------------------------------------------------------------
// mgtt_pkg: shared types and constants of the Modbus gateway tracker
// Event and action codes, frame constants and the CRC-16/MODBUS byte step.
// ----------------------------------------------------------------------------
package mgtt_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LEN_W     = 9;

  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 56;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_RESPONSE = 2'd1,
    OP_STATUS   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_RELAY   = 2'd1,
    ACT_EXC     = 2'd2
  } action_e;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_TWO = 2'd1;

  localparam logic [7:0]       UNIT_ONE      = 8'd1;
  localparam logic [7:0]       UNIT_TWO      = 8'd2;
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 9'd4;
  localparam logic [7:0]       EXC_FLAG      = 8'h80;
  localparam logic [7:0]       EXC_CODE      = 8'h0B;
  localparam logic [15:0]      CRC_INIT      = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY      = 16'hA001;
  localparam logic [2:0]       EXC_LEN       = 3'd5;

  // Frame index where each exception byte sits.
  localparam logic [2:0] IDX_UNIT   = 3'd0;
  localparam logic [2:0] IDX_FUNC   = 3'd1;
  localparam logic [2:0] IDX_CODE   = 3'd2;
  localparam logic [2:0] IDX_CRC_LO = 3'd3;
  localparam logic [2:0] IDX_CRC_HI = 3'd4;

  // Result to be handed to the output stage.
  typedef struct packed {
    logic              valid;
    action_e           action;
    logic [ADDR_W-1:0] target;
    logic [7:0]        unit;
    logic [7:0]        func;
  } load_t;

  // One byte of CRC-16/MODBUS, reflected, eight shift steps.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/modbus_gateway_transaction_tracker.sv]
// ----------------------------------------------------------------------------
// modbus_gateway_transaction_tracker: Modbus gateway transaction tracker
// Routes requests to node link addresses, tracks the pending transaction and
// emits Modbus exception frames with CRC-16/MODBUS on failed sends.
// ----------------------------------------------------------------------------
// Path: an accepted event waits in the input register until the output
//   stage can take its result, which is registered there before it is sent.
// Throughput: one event per cycle for dropped events, and for forwards and
//   relays while the result sink is ready; an exception sends five frame bytes.
// Reset: rst_ni is asynchronous, active low; it clears the node addresses,
//   the pending transaction and both pipeline stages. No clearing pass.
// ----------------------------------------------------------------------------
module modbus_gateway_transaction_tracker
  import mgtt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  // Event stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // unit_id[7:0], func_code[15:8], frame_length[24:16], status_address[72:25],
  // send_ok[73], zero fill[79:74]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,   // operation[1:0]
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // target_address[47:0], tx_byte[55:48]
  output logic [1:0]           m_axis_tuser,   // action[1:0]
  output logic                 m_axis_tlast    // last_byte
);

  // Configured link addresses of the two remote nodes.
  logic [ADDR_W-1:0] node_one_q, node_two_q;

  // Input register: one event waiting for its decision.
  logic              in_valid_q;
  logic [1:0]        in_op_q;
  logic [7:0]        in_unit_q;
  logic [7:0]        in_func_q;
  logic [LEN_W-1:0]  in_len_q;
  logic [ADDR_W-1:0] in_saddr_q;
  logic              in_ok_q;

  // The pending transaction.
  logic              pend_active_q, pend_active_d;
  logic [7:0]        pend_unit_q, pend_unit_d;
  logic [7:0]        pend_func_q, pend_func_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;

  logic              req_ok;
  logic              exc_hit;
  logic              has_res;
  logic              take;
  logic              s_hs;
  logic              tx_free;
  logic [ADDR_W-1:0] req_target;
  action_e           res_action;
  load_t             load;

  // Configuration writes; an index past the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_one_q <= '0;
      node_two_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_NODE_ONE) begin
        node_one_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_NODE_TWO) begin
        node_two_q <= cfg_wdata_i;
      end
    end
  end

  // The input register accepts a new event whenever it is empty or its
  // event moves on in this cycle, so events stream back to back.
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      in_op_q    <= s_axis_tuser;
      in_unit_q  <= s_axis_tdata[7:0];
      in_func_q  <= s_axis_tdata[15:8];
      in_len_q   <= s_axis_tdata[24:16];
      in_saddr_q <= s_axis_tdata[72:25];
      in_ok_q    <= s_axis_tdata[73];
    end
  end

  // Decision. A request needs a frame of at least four bytes and a known unit id; a
  // failed send only counts when it names the pending node.
  assign req_ok     = (in_len_q >= MIN_FRAME_LEN) &&
                      (in_unit_q == UNIT_ONE || in_unit_q == UNIT_TWO);
  assign req_target = (in_unit_q == UNIT_ONE) ? node_one_q : node_two_q;
  assign exc_hit    = !in_ok_q && pend_active_q && (pend_addr_q == in_saddr_q);

  always_comb begin
    case (op_e'(in_op_q))
      OP_REQUEST: begin
        has_res    = req_ok;
        res_action = ACT_FORWARD;
      end
      OP_RESPONSE: begin
        has_res    = 1'b1;
        res_action = ACT_RELAY;
      end
      OP_STATUS: begin
        has_res    = exc_hit;
        res_action = ACT_EXC;
      end
      default: begin
        has_res    = 1'b0;
        res_action = ACT_RELAY;
      end
    endcase
  end

  // An event with no result leaves at once; one with results waits until the output
  // stage is idle or is handing over its last transaction.
  assign take = in_valid_q && (!has_res || tx_free);

  always_comb begin
    pend_active_d = pend_active_q;
    pend_unit_d   = pend_unit_q;
    pend_func_d   = pend_func_q;
    pend_addr_d   = pend_addr_q;
    if (take && has_res) begin
      case (res_action)
        ACT_FORWARD: begin
          pend_active_d = 1'b1;
          pend_unit_d   = in_unit_q;
          pend_func_d   = in_func_q;
          pend_addr_d   = req_target;
        end
        ACT_RELAY, ACT_EXC: begin
          pend_active_d = 1'b0;
        end
        default: begin
          pend_active_d = pend_active_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_active_q <= 1'b0;
      pend_unit_q   <= '0;
      pend_func_q   <= '0;
      pend_addr_q   <= '0;
    end else begin
      pend_active_q <= pend_active_d;
      pend_unit_q   <= pend_unit_d;
      pend_func_q   <= pend_func_d;
      pend_addr_q   <= pend_addr_d;
    end
  end

  // The exception frame captures the pending unit and function now, so a
  // later request cannot disturb a frame still being sent.
  always_comb begin
    load.valid  = take && has_res;
    load.action = res_action;
    load.target = (res_action == ACT_FORWARD) ? req_target : '0;
    load.unit   = pend_unit_q;
    load.func   = pend_func_q;
  end

  mgtt_result_tx u_result_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .free_o        (tx_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Any event that produces results ends with no transaction pending,
  // unless it is a forwarded request.
  a_pend_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && has_res && res_action != ACT_FORWARD) |=> !pend_active_q)
    else $error("pending transaction not cleared");

  // A forwarded request always leaves a pending transaction at its target.
  a_pend_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && has_res && res_action == ACT_FORWARD) |=>
      (pend_active_q && pend_addr_q == $past(req_target)))
    else $error("pending transaction not recorded");

  // Forward and relay results carry no frame byte.
  a_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ACT_EXC) |-> m_axis_tdata[55:48] == 8'h00)
    else $error("frame byte set on a non-exception result");

endmodule

[rtl/mgtt_result_tx.sv]
// ----------------------------------------------------------------------------
// mgtt_result_tx: result output stage
// Holds one result set and plays it out one transaction per cycle while the sink
// is ready; builds the exception frame bytes and runs the CRC over the header bytes.
// ----------------------------------------------------------------------------
module mgtt_result_tx
  import mgtt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  load_t                load_i,
  output logic                 free_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // target_address[47:0], tx_byte[55:48]
  output logic [1:0]           m_axis_tuser,   // action[1:0]
  output logic                 m_axis_tlast
);

  logic [2:0]        cnt_q, cnt_d;
  logic [2:0]        idx_q, idx_d;
  action_e           act_q, act_d;
  logic [ADDR_W-1:0] tgt_q, tgt_d;
  logic [7:0]        unit_q, unit_d;
  logic [7:0]        func_q, func_d;
  logic [15:0]       crc_q, crc_d;
  logic              hs;
  logic [7:0]        byte_sel;
  logic [7:0]        crc_in;

  assign hs     = (cnt_q != 3'd0) && m_axis_tready;
  assign free_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_axis_tready);

  assign crc_in = (idx_q == IDX_UNIT) ? (func_q | EXC_FLAG) : EXC_CODE;

  always_comb begin
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    act_d  = act_q;
    tgt_d  = tgt_q;
    unit_d = unit_q;
    func_d = func_q;
    crc_d  = crc_q;
    if (hs) begin
      cnt_d = cnt_q - 3'd1;
      idx_d = idx_q + 3'd1;
      // Fold in the function and code bytes while the first two go out.
      if (idx_q == IDX_UNIT || idx_q == IDX_FUNC) begin
        crc_d = crc_step(crc_q, crc_in);
      end
    end
    if (load_i.valid) begin
      cnt_d  = (load_i.action == ACT_EXC) ? EXC_LEN : 3'd1;
      idx_d  = IDX_UNIT;
      act_d  = load_i.action;
      tgt_d  = load_i.target;
      unit_d = load_i.unit;
      func_d = load_i.func;
      crc_d  = crc_step(CRC_INIT, load_i.unit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= IDX_UNIT;
      act_q <= ACT_FORWARD;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q  <= tgt_d;
    unit_q <= unit_d;
    func_q <= func_d;
    crc_q  <= crc_d;
  end

  always_comb begin
    case (idx_q)
      IDX_UNIT:   byte_sel = unit_q;
      IDX_FUNC:   byte_sel = func_q | EXC_FLAG;
      IDX_CODE:   byte_sel = EXC_CODE;
      IDX_CRC_LO: byte_sel = crc_q[7:0];
      IDX_CRC_HI: byte_sel = crc_q[15:8];
      default:    byte_sel = 8'h00;
    endcase
  end

  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tuser  = act_q;
  assign m_axis_tlast  = (cnt_q == 3'd1);
  assign m_axis_tdata  = (act_q == ACT_EXC) ? {byte_sel, {ADDR_W{1'b0}}}
                                            : {8'h00, tgt_q};

  // A new result set only arrives when the stage is idle or the current one is draining.
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.valid |-> free_o)
    else $error("result stage overwritten while busy");

  // The high CRC byte is always the final byte of an exception frame.
  a_crc_hi_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 3'd0 && act_q == ACT_EXC && idx_q == IDX_CRC_HI) |-> cnt_q == 3'd1)
    else $error("exception frame length mismatch");

  // Non-exception results come one per event.
  a_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 3'd0 && act_q != ACT_EXC) |-> cnt_q == 3'd1)
    else $error("forward or relay result repeated");

endmodule

[verif/modbus_gateway_transaction_tracker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_gateway_transaction_tracker_tb: self-checking bench of the tracker
// Sends request, response and send status events with bursty timing against a
// stalling result sink. An untimed model of the tracker predicts the forward,
// relay and exception bytes, apart from directed rows with a typed result, and
// each result transaction is compared with the oldest prediction field by field.
// ----------------------------------------------------------------------------
module modbus_gateway_transaction_tracker_tb;
  import mgtt_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 9;
  // Quiet time added after the last expected result, so that the block is
  // idle for a register write.
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 12;
  localparam int STALL_LIMIT    = 2000;
  localparam int RAND_PHASES    = 4;
  localparam int RAND_PER_PHASE = 50;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_STEPS      = 28;

  // Codes that the package leaves unnamed because the block ignores them.
  localparam logic [1:0]           OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [ADDR_W-1:0]    ADDR_ONES   = '1;

  // One result transaction as it appears on the result stream.
  typedef struct packed {
    action_e           action;
    logic [ADDR_W-1:0] target;
    logic [7:0]        tx_byte;
    logic              last;
  } reply_t;

  // How a directed row is checked: by the model, or by a value typed in.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_FORWARD,
    CHK_RELAY
  } check_e;

  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        code;   // Operation, or register index on a config row.
    logic [7:0]        unit;
    logic [7:0]        func;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;   // Status address, or register value.
    logic              ok;
    check_e            chk;
    logic [ADDR_W-1:0] tgt;    // Typed forward target.
  } step_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_CHOKED
  } rx_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [ADDR_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  // Model copy of the node addresses and of the pending transaction.
  logic [ADDR_W-1:0] node_addr [2];
  logic              trk_active;
  logic [7:0]        trk_unit;
  logic [7:0]        trk_func;
  logic [ADDR_W-1:0] trk_addr;

  // Results that the tracker still owes, oldest first.
  reply_t reply_q [$];

  step_t    steps [DIR_STEPS];
  int       fault_cnt    = 0;
  int       answered_cnt = 0;
  int       burst_left   = 0;
  int       quiet_cycles = 0;
  int       stall_run    = 0;
  rx_mode_e stall_mode   = RX_OPEN;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  modbus_gateway_transaction_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [ADDR_W-1:0] rand48();
    logic [ADDR_W-1:0] v;
    v[31:0]  = $urandom;
    v[47:32] = 16'($urandom);
    return v;
  endfunction

  task automatic log_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Applies one event to the tracker model and, when asked, queues the results
  // it owes. Returns how many results the event causes.
  function automatic int gateway_event(input logic [1:0] op, input logic [7:0] unit,
                                       input logic [7:0] func, input logic [LEN_W-1:0] len,
                                       input logic [ADDR_W-1:0] saddr, input logic ok,
                                       input bit keep);
    logic [ADDR_W-1:0] dest;
    logic [7:0]        frame [5];
    logic [15:0]       crc;
    logic              fb;
    int                cnt;
    cnt = 0;
    case (op)
      OP_REQUEST: begin
        // Short frames and unit ids other than the two nodes are dropped.
        if (len >= MIN_FRAME_LEN && (unit == UNIT_ONE || unit == UNIT_TWO)) begin
          dest       = (unit == UNIT_ONE) ? node_addr[0] : node_addr[1];
          trk_active = 1'b1;
          trk_unit   = unit;
          trk_func   = func;
          trk_addr   = dest;
          cnt        = 1;
          if (keep) begin
            reply_q.push_back(reply_t'{ACT_FORWARD, dest, 8'h00, 1'b1});
          end
        end
      end
      OP_RESPONSE: begin
        // A response is relayed even when nothing is pending.
        trk_active = 1'b0;
        cnt        = 1;
        if (keep) begin
          reply_q.push_back(reply_t'{ACT_RELAY, '0, 8'h00, 1'b1});
        end
      end
      OP_STATUS: begin
        if (!ok && trk_active && trk_addr == saddr) begin
          frame[0] = trk_unit;
          frame[1] = trk_func | EXC_FLAG;
          frame[2] = EXC_CODE;
          // CRC-16/MODBUS over the three header bytes, one bit at a time,
          // least significant bit of each byte first.
          crc = CRC_INIT;
          for (int i = 0; i < 24; i++) begin
            fb  = crc[0] ^ frame[i / 8][i % 8];
            crc = crc >> 1;
            if (fb) begin
              crc = crc ^ CRC_POLY;
            end
          end
          frame[3]   = crc[7:0];
          frame[4]   = crc[15:8];
          trk_active = 1'b0;
          cnt        = 5;
          if (keep) begin
            for (int i = 0; i < 5; i++) begin
              reply_q.push_back(reply_t'{ACT_EXC, '0, frame[i], 1'(i == 4)});
            end
          end
        end
      end
      default: begin
      end
    endcase
    return cnt;
  endfunction

  // Offers one event on the event stream and returns once it is accepted.
  // The sender works in bursts; between bursts valid drops for a random gap.
  task automatic send_event(input logic [1:0] op, input logic [7:0] unit,
                            input logic [7:0] func, input logic [LEN_W-1:0] len,
                            input logic [ADDR_W-1:0] saddr, input logic ok, input bit keep);
    int gap;
    int n;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, ok, saddr, len, func, unit};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
    end
    n = gateway_event(op, unit, func, len, saddr, ok, keep);
    if (n > 0) begin
      answered_cnt++;
    end
  endtask

  task automatic send_status(input logic [ADDR_W-1:0] saddr, input logic ok);
    send_event(OP_STATUS, 8'($urandom), 8'($urandom), LEN_W'($urandom), saddr, ok, 1'b1);
  endtask

  // Ends the current burst and waits until the tracker has nothing left to
  // deliver, so that a register write cannot hit an event in flight.
  task automatic settle();
    if (burst_left != 0) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (reply_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NODE_ONE) begin
      node_addr[0] = val;
    end else if (idx == REG_NODE_TWO) begin
      node_addr[1] = val;
    end
  endtask

  // The result sink changes its mood now and then: always ready, ready at
  // random, or mostly stalled. Each mood lasts a random stretch of cycles.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= rx_mode_e'($urandom_range(0, 2));
      stall_run  <= $urandom_range(4, 40);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
      default:   m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = reply_t'{action_e'(m_axis_tuser), m_axis_tdata[47:0], m_axis_tdata[55:48],
                     m_axis_tlast};
      if (reply_q.size() == 0) begin
        log_fault($sformatf("unexpected result: action=%0d target=%h byte=%h last=%b",
                            got.action, got.target, got.tx_byte, got.last));
      end else begin
        want = reply_q.pop_front();
        if (got !== want) begin
          log_fault($sformatf({"result mismatch: expected action=%0d target=%h byte=%h ",
                               "last=%b, got action=%0d target=%h byte=%h last=%b"},
                              want.action, want.target, want.tx_byte, want.last,
                              got.action, got.target, got.tx_byte, got.last));
        end
      end
    end
  end

  // Watchdog: too many cycles without a transaction on either stream means
  // the tracker has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]        unit;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] a_one;
    logic [ADDR_W-1:0] a_two;
    logic [ADDR_W-1:0] hit;
    int                goal;

    // Directed events. The first rows run with both node addresses still at
    // their reset value of zero, so a failed send to address zero matches.
    steps = '{
      '{1'b0, OP_REQUEST,  8'h01, 8'h03, 9'd4,   48'h0,            1'b0, CHK_FORWARD, 48'h0},
      '{1'b0, OP_STATUS,   8'h00, 8'h00, 9'd0,   48'h0,            1'b0, CHK_MODEL,   48'h0},
      '{1'b0, OP_RESPONSE, 8'h00, 8'h00, 9'd0,   48'h0,            1'b0, CHK_RELAY,   48'h0},
      // Nothing is pending any more, so the failed send is dropped.
      '{1'b0, OP_STATUS,   8'h00, 8'h00, 9'd0,   48'h0,            1'b0, CHK_NONE,    48'h0},
      '{1'b1, REG_NODE_ONE, 8'h00, 8'h00, 9'd0,  ADDR_ONES,        1'b0, CHK_NONE,    48'h0},
      // Writes to the spare indexes must not touch either node address.
      '{1'b1, REG_SPARE_A, 8'h00, 8'h00, 9'd0,   48'h123456789ABC, 1'b0, CHK_NONE,    48'h0},
      '{1'b1, REG_SPARE_B, 8'h00, 8'h00, 9'd0,   ADDR_ONES,        1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_REQUEST,  8'h01, 8'hFF, 9'd256, 48'h0,            1'b0, CHK_FORWARD, ADDR_ONES},
      // A delivered send and a failed send to another address are dropped.
      '{1'b0, OP_STATUS,   8'h00, 8'h00, 9'd0,   ADDR_ONES,        1'b1, CHK_NONE,    48'h0},
      '{1'b0, OP_STATUS,   8'h00, 8'h00, 9'd0,   48'hFFFFFFFFFFFE, 1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_STATUS,   8'hFF, 8'hFF, 9'd511, ADDR_ONES,        1'b0, CHK_MODEL,   48'h0},
      '{1'b0, OP_REQUEST,  8'h02, 8'h00, 9'd4,   48'h0,            1'b0, CHK_FORWARD, 48'h0},
      // Unknown unit ids, short frames and the unused operation are dropped.
      '{1'b0, OP_REQUEST,  8'h00, 8'h01, 9'd100, 48'h0,            1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_REQUEST,  8'hFF, 8'h01, 9'd511, 48'h0,            1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_REQUEST,  8'h01, 8'h10, 9'd3,   48'h0,            1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_REQUEST,  8'h02, 8'h10, 9'd0,   48'h0,            1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_UNUSED,   8'h01, 8'h01, 9'd8,   48'h0,            1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_STATUS,   8'h00, 8'h00, 9'd0,   48'h0,            1'b0, CHK_MODEL,   48'h0},
      '{1'b0, OP_RESPONSE, 8'hFF, 8'hFF, 9'd511, ADDR_ONES,        1'b1, CHK_RELAY,   48'h0},
      '{1'b1, REG_NODE_TWO, 8'h00, 8'h00, 9'd0,  48'h800000000001, 1'b0, CHK_NONE,    48'h0},
      '{1'b1, REG_NODE_ONE, 8'h00, 8'h00, 9'd0,  48'h0,            1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_REQUEST,  8'h02, 8'h7F, 9'd5,   48'h0,            1'b0, CHK_FORWARD,
        48'h800000000001},
      // A newer request replaces the pending one, so the old address no
      // longer matches.
      '{1'b0, OP_REQUEST,  8'h01, 8'h2B, 9'd4,   48'h0,            1'b0, CHK_FORWARD, 48'h0},
      '{1'b0, OP_STATUS,   8'h00, 8'h00, 9'd0,   48'h800000000001, 1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_RESPONSE, 8'h00, 8'h00, 9'd0,   48'h0,            1'b0, CHK_RELAY,   48'h0},
      '{1'b0, OP_STATUS,   8'h00, 8'h00, 9'd0,   48'h0,            1'b0, CHK_NONE,    48'h0},
      '{1'b0, OP_REQUEST,  8'h01, 8'h01, 9'd8,   48'h0,            1'b0, CHK_FORWARD, 48'h0},
      '{1'b0, OP_STATUS,   8'h00, 8'h00, 9'd0,   48'h0,            1'b0, CHK_MODEL,   48'h0}
    };

    node_addr[0] = '0;
    node_addr[1] = '0;
    trk_active   = 1'b0;
    trk_unit     = '0;
    trk_func     = '0;
    trk_addr     = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rows with a typed result still run through the model so that its
    // pending transaction follows the tracker.
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        settle();
        write_reg(steps[i].code, steps[i].addr);
      end else begin
        send_event(steps[i].code, steps[i].unit, steps[i].func, steps[i].len,
                   steps[i].addr, steps[i].ok, steps[i].chk == CHK_MODEL);
        case (steps[i].chk)
          CHK_FORWARD: reply_q.push_back(reply_t'{ACT_FORWARD, steps[i].tgt, 8'h00, 1'b1});
          CHK_RELAY:   reply_q.push_back(reply_t'{ACT_RELAY, '0, 8'h00, 1'b1});
          default: begin
          end
        endcase
      end
    end

    // Random phases, each under its own pair of node addresses. Most traffic
    // is a routed request followed by a status or response that refers to it;
    // the rest is noise over every field.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          a_one = ADDR_ONES;
          a_two = '0;
        end
        1: begin
          a_one = rand48();
          a_two = rand48();
        end
        2: begin
          // Both nodes share one link address.
          a_one = rand48();
          a_two = a_one;
        end
        default: begin
          a_one = '0;
          a_two = ADDR_ONES;
        end
      endcase
      write_reg(REG_NODE_ONE, a_one);
      write_reg(REG_NODE_TWO, a_two);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B, rand48());
      end
      goal = answered_cnt + RAND_PER_PHASE;
      while (answered_cnt < goal) begin
        if ($urandom_range(0, 99) < 70) begin
          unit = 8'($urandom_range(1, 2));
          hit  = node_addr[unit[1]];
          case ($urandom_range(0, 9))
            0:       len = MIN_FRAME_LEN;
            1:       len = 9'd256;
            2:       len = LEN_W'($urandom_range(257, 511));
            default: len = LEN_W'($urandom_range(4, 64));
          endcase
          send_event(OP_REQUEST, unit, 8'($urandom), len, rand48(), 1'($urandom), 1'b1);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: send_status(hit, 1'b0);
            6: send_event(OP_RESPONSE, 8'($urandom), 8'($urandom), LEN_W'($urandom),
                          rand48(), 1'($urandom), 1'b1);
            7: begin
              send_status(hit, 1'b1);
              send_status(hit, 1'b0);
            end
            8: begin
              send_status(hit ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1)), 1'b0);
              send_status(hit, 1'b0);
            end
            default: begin
            end
          endcase
        end else begin
          hit = ($urandom_range(0, 1) == 1) ? trk_addr : rand48();
          send_event(2'($urandom), 8'($urandom), 8'($urandom), LEN_W'($urandom), hit,
                     1'($urandom), 1'b1);
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (reply_q.size() != 0) begin
      log_fault($sformatf("%0d expected results never arrived", reply_q.size()));
    end
    if (fault_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
